// ===== rtl/core/ial_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_pkg
// Shared constants, codes and types of the indexed array list.
// ----------------------------------------------------------------------------
package ial_pkg;

  // list geometry
  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  // request field widths
  localparam int ACT_BITS  = 3;
  localparam int POS_BITS  = 5;
  localparam int STAT_BITS = 2;

  // action codes
  localparam logic [ACT_BITS-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_FRONT  = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_APPEND = 3'd4;
  localparam logic [ACT_BITS-1:0] ACT_REMOVE = 3'd5;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

  // per-cell operation broadcast along the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [CNT_BITS-1:0]    pos;
    logic [WORD_BITS-1:0]   word;
  } cell_cmd_t;

  // request outcome from the controller
  typedef struct packed {
    logic [STAT_BITS-1:0]   status;
    logic [CNT_BITS-1:0]    count;
    logic                   rd_en;
  } ctrl_res_t;

endpackage

// ===== rtl/core/ial_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_cell
// One list slot: holds a word, or loads the command word or its lower or upper
// neighbor's word as the broadcast command asks.
// ----------------------------------------------------------------------------
module ial_cell
  import ial_pkg::*;
(
  input  logic                 clk_i,
  input  logic [CNT_BITS-1:0]  idx_i,
  input  cell_cmd_t            cmd_i,
  input  logic [WORD_BITS-1:0] prev_i,
  input  logic [WORD_BITS-1:0] next_i,
  output logic [WORD_BITS-1:0] slot_o
);

  logic [WORD_BITS-1:0] slot_q, slot_d;

  // select the next slot content
  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      CELL_WRITE: begin
        if (idx_i == cmd_i.pos) slot_d = cmd_i.word;
      end
      CELL_OPEN: begin
        // words above the gap move up one place
        if (idx_i > cmd_i.pos) slot_d = prev_i;
        else if (idx_i == cmd_i.pos) slot_d = cmd_i.word;
      end
      CELL_CLOSE: begin
        // words from the removed place on move down one place
        if (idx_i >= cmd_i.pos) slot_d = next_i;
      end
      default: slot_d = slot_q;
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/core/ial_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_ctrl
// Request decode: range and full checks, new length and the command that
// goes to every cell of the chain.
// ----------------------------------------------------------------------------
module ial_ctrl
  import ial_pkg::*;
(
  input  logic                 fire_i,
  input  logic [ACT_BITS-1:0]  action_i,
  input  logic [POS_BITS-1:0]  position_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [CNT_BITS-1:0]  used_i,
  output cell_cmd_t            cmd_o,
  output ctrl_res_t            res_o
);

  logic                full;
  logic                in_range;
  logic [CNT_BITS-1:0] pos;
  cell_op_e            op;

  assign full     = (used_i == CNT_BITS'(CAPACITY));
  assign in_range = ({1'b0, position_i} < {{(POS_BITS + 1 - CNT_BITS){1'b0}}, used_i});

  // decode one request
  always_comb begin
    op            = CELL_HOLD;
    pos           = CNT_BITS'(position_i);
    res_o.status  = ST_OK;
    res_o.count   = used_i;
    res_o.rd_en   = 1'b0;
    case (action_i)
      ACT_READ: begin
        if (in_range) res_o.rd_en = 1'b1;
        else res_o.status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (in_range) op = CELL_WRITE;
        else res_o.status = ST_RANGE;
      end
      ACT_INSERT: begin
        if ({1'b0, position_i} > {{(POS_BITS + 1 - CNT_BITS){1'b0}}, used_i}) begin
          res_o.status = ST_RANGE;
        end else if (full) begin
          res_o.status = ST_FULL;
        end else begin
          op          = CELL_OPEN;
          res_o.count = used_i + 1'b1;
        end
      end
      ACT_FRONT: begin
        pos = '0;
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          op          = CELL_OPEN;
          res_o.count = used_i + 1'b1;
        end
      end
      ACT_APPEND: begin
        pos = used_i;
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          op          = CELL_OPEN;
          res_o.count = used_i + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (in_range) begin
          op          = CELL_CLOSE;
          res_o.count = used_i - 1'b1;
        end else begin
          res_o.status = ST_RANGE;
        end
      end
      default: op = CELL_HOLD;
    endcase
  end

  // cells only move on an accepted request
  assign cmd_o.op   = fire_i ? op : CELL_HOLD;
  assign cmd_o.pos  = pos;
  assign cmd_o.word = value_i;

endmodule

// ===== rtl/core/indexed_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list
// Ordered list of up to CAPACITY words kept in a chain of slot cells;
// read, overwrite, insert at index, insert front, append and remove.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   req_valid/ready     action, position, value
//  result    rsp_valid/ready     read_value, count, status
//
//  all cells shift in the same edge, so a new request is taken each cycle
//  while the result register drains. the result register sits between
//  the sides; a request is taken when it is empty or being emptied in the
//  same cycle.
//  reset clears the length and the result valid; slot contents stay as is.
// ----------------------------------------------------------------------------
module indexed_array_list
  import ial_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [ACT_BITS-1:0]   action_i,
  input  logic [POS_BITS-1:0]   position_i,
  input  logic [WORD_BITS-1:0]  value_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [WORD_BITS-1:0]  read_value_o,
  output logic [CNT_BITS-1:0]   count_o,
  output logic [STAT_BITS-1:0]  status_o
);

  logic                 fire;
  logic [CNT_BITS-1:0]  used_q, used_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [WORD_BITS-1:0] read_value_q, read_value_d;
  logic [CNT_BITS-1:0]  count_q;
  logic [STAT_BITS-1:0] status_q;
  cell_cmd_t            cmd;
  ctrl_res_t            res;
  logic [WORD_BITS-1:0] slots [CAPACITY];

  // handshake
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = req_valid_i && req_ready_o;

  // request decode
  ial_ctrl u_ctrl (
    .fire_i     (fire),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .used_i     (used_q),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  // chain of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = cmd.word;
    end else begin : g_mid_prev
      assign prev_w = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = slots[i+1];
    end
    ial_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (CNT_BITS'(i)),
      .cmd_i  (cmd),
      .prev_i (prev_w),
      .next_i (next_w),
      .slot_o (slots[i])
    );
  end

  // read word and length update
  assign read_value_d = res.rd_en ? slots[position_i[IDX_BITS-1:0]] : '0;
  assign used_d       = fire ? res.count : used_q;
  assign rsp_valid_d  = fire ? 1'b1 : (rsp_ready_i ? 1'b0 : rsp_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= read_value_d;
      count_q      <= res.count;
      status_q     <= res.status;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign read_value_o = read_value_q;
  assign count_o      = count_q;
  assign status_o     = status_q;

endmodule

// ===== dv/ial_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ial_checker
// Watches both channels of the indexed array list, keeps its own copy of
// the stored words and length, and compares every result with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module ial_checker
  import ial_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [ACT_BITS-1:0]   action_i,
  input  logic [POS_BITS-1:0]   position_i,
  input  logic [WORD_BITS-1:0]  value_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [WORD_BITS-1:0]  read_value_i,
  input  logic [CNT_BITS-1:0]   count_i,
  input  logic [STAT_BITS-1:0]  status_i,
  output int                    err_count_o,
  output int                    pending_o,
  output int                    fill_o,
  output int                    checked_o,
  output int                    range_hits_o,
  output int                    full_hits_o
);

  typedef struct packed {
    logic [WORD_BITS-1:0]  word;
    logic [CNT_BITS-1:0]   count;
    logic [STAT_BITS-1:0]  status;
  } list_result_t;

  // shadow copy of the list
  logic [WORD_BITS-1:0] words_q [CAPACITY];
  int unsigned          length_q;
  list_result_t         outcome_q [$];

  task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] want,
                                 input logic [WORD_BITS-1:0] got);
    $display("[%0t] indexed_array_list mismatch: %s expected %0h got %0h",
             $time, what, want, got);
    err_count_o++;
  endtask

  // apply one request to the shadow list and return its outcome
  function automatic list_result_t apply_request(input logic [ACT_BITS-1:0] act,
                                                 input logic [POS_BITS-1:0] pos,
                                                 input logic [WORD_BITS-1:0] word);
    list_result_t res;
    int unsigned  at;
    int unsigned  k;
    logic         grow;
    res        = '0;
    res.status = ST_OK;
    at         = 32'(pos);
    grow       = 1'b0;
    case (act)
      ACT_READ: begin
        if (at < length_q) res.word = words_q[IDX_BITS'(at)];
        else res.status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (at < length_q) words_q[IDX_BITS'(at)] = word;
        else res.status = ST_RANGE;
      end
      ACT_INSERT: begin
        // range test wins over the full test
        if (at > length_q) res.status = ST_RANGE;
        else if (length_q >= CAPACITY) res.status = ST_FULL;
        else grow = 1'b1;
      end
      ACT_FRONT: begin
        at = 0;
        if (length_q >= CAPACITY) res.status = ST_FULL;
        else grow = 1'b1;
      end
      ACT_APPEND: begin
        at = length_q;
        if (length_q >= CAPACITY) res.status = ST_FULL;
        else grow = 1'b1;
      end
      ACT_REMOVE: begin
        if (at < length_q) begin
          for (k = at; k + 1 < length_q; k++)
            words_q[IDX_BITS'(k)] = words_q[IDX_BITS'(k + 1)];
          length_q--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    // open a gap at the insert point, later words move up
    if (grow) begin
      for (k = length_q; k > at; k--) words_q[IDX_BITS'(k)] = words_q[IDX_BITS'(k - 1)];
      words_q[IDX_BITS'(at)] = word;
      length_q++;
    end
    res.count = CNT_BITS'(length_q);
    return res;
  endfunction

  // compare accepted results, then predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want;
    if (!rst_ni) begin
      length_q = 0;
      outcome_q.delete();
      pending_o <= 0;
      fill_o    <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request waiting", '0, read_value_i);
        end else begin
          want = outcome_q.pop_front();
          if (read_value_i !== want.word) report_mismatch("read_value", want.word, read_value_i);
          if (count_i !== want.count)
            report_mismatch("count", WORD_BITS'(want.count), WORD_BITS'(count_i));
          if (status_i !== want.status)
            report_mismatch("status", WORD_BITS'(want.status), WORD_BITS'(status_i));
          if (want.status == ST_RANGE) range_hits_o++;
          if (want.status == ST_FULL) full_hits_o++;
          checked_o++;
        end
      end
      if (req_valid_i && req_ready_i)
        outcome_q.push_back(apply_request(action_i, position_i, value_i));
      pending_o <= outcome_q.size();
      fill_o    <= length_q;
    end
  end

endmodule

// ===== dv/indexed_array_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_list_tb
// Drives read, overwrite, insert, front insert, append and remove requests
// into the list under several handshake mixes; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module indexed_array_list_tb
  import ial_pkg::*;
();

  // action codes the block leaves unused
  localparam logic [ACT_BITS-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_BITS-1:0] ACT_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 225;
  localparam int HOLD_CYCLES   = 48;
  localparam int BURST_ITEMS   = 12;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  req_valid_i  = 1'b0;
  logic                  req_ready_o;
  logic [ACT_BITS-1:0]   action_i     = ACT_READ;
  logic [POS_BITS-1:0]   position_i   = '0;
  logic [WORD_BITS-1:0]  value_i      = '0;
  logic                  rsp_valid_o;
  logic                  rsp_ready_i  = 1'b0;
  logic [WORD_BITS-1:0]  read_value_o;
  logic [CNT_BITS-1:0]   count_o;
  logic [STAT_BITS-1:0]  status_o;

  int err_count;
  int pending;
  int fill;
  int checked;
  int range_hits;
  int full_hits;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;
  bit grow_mode     = 1'b1;
  int sent_count    = 0;
  int cycles        = 0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  indexed_array_list uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  ial_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_i  (req_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .read_value_i (read_value_o),
    .count_i      (count_o),
    .status_i     (status_o),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .fill_o       (fill),
    .checked_o    (checked),
    .range_hits_o (range_hits),
    .full_hits_o  (full_hits)
  );

  // result side: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("indexed_array_list_tb: done, errors");
      $finish;
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [ACT_BITS-1:0] act, input logic [POS_BITS-1:0] pos,
                              input logic [WORD_BITS-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    action_i    <= act;
    position_i  <= pos;
    value_i     <= word;
    do @(posedge clk_i); while (!req_ready_o);
    sent_count++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // mostly well-formed requests, drifting the length between empty and full
  task automatic send_random_request();
    logic [ACT_BITS-1:0]   act;
    logic [POS_BITS-1:0]   pos;
    logic [WORD_BITS-1:0]  word;
    int                    r;
    if (fill >= CAPACITY && $urandom_range(0, 99) < 20) grow_mode = 1'b0;
    else if (fill == 0 && $urandom_range(0, 99) < 30) grow_mode = 1'b1;
    else if ($urandom_range(0, 99) < 2) grow_mode = !grow_mode;
    r = $urandom_range(0, 99);
    if (grow_mode) begin
      if (r < 20) act = ACT_INSERT;
      else if (r < 35) act = ACT_FRONT;
      else if (r < 55) act = ACT_APPEND;
      else if (r < 70) act = ACT_READ;
      else if (r < 82) act = ACT_WRITE;
      else if (r < 97) act = ACT_REMOVE;
      else act = r[0] ? ACT_SPARE_A : ACT_SPARE_B;
    end else begin
      if (r < 8) act = ACT_INSERT;
      else if (r < 13) act = ACT_FRONT;
      else if (r < 20) act = ACT_APPEND;
      else if (r < 35) act = ACT_READ;
      else if (r < 47) act = ACT_WRITE;
      else if (r < 97) act = ACT_REMOVE;
      else act = r[0] ? ACT_SPARE_A : ACT_SPARE_B;
    end
    r = $urandom_range(0, 99);
    if (r < 85) pos = POS_BITS'($urandom_range(0, (fill > CAPACITY) ? CAPACITY : fill));
    else if (r < 95) pos = POS_BITS'($urandom_range(0, CAPACITY));
    else pos = POS_BITS'($urandom_range(CAPACITY + 1, (1 << POS_BITS) - 1));
    r = $urandom_range(0, 99);
    if (r < 5) word = '0;
    else if (r < 10) word = '1;
    else word = $urandom();
    send_request(act, pos, word);
  endtask

  initial begin : stimulus
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 88, 0, 30};
    stall_mix = '{0, 0, 88, 30};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, fill to capacity, full and range corners
    send_request(ACT_READ, '0, '0);
    send_request(ACT_WRITE, '0, 32'h1234_5678);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_INSERT, 5'd1, 32'hdead_beef);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_FRONT, '0, '1);
    send_request(ACT_APPEND, '0, 32'h8000_0001);
    for (int i = 0; i < CAPACITY - 3; i++) send_request(ACT_APPEND, '0, $urandom());
    send_request(ACT_INSERT, 5'(CAPACITY), 32'h5a5a_5a5a);
    send_request(ACT_INSERT, 5'(CAPACITY + 1), 32'ha5a5_a5a5);
    send_request(ACT_FRONT, '0, 32'h0f0f_0f0f);
    send_request(ACT_APPEND, '0, 32'hf0f0_f0f0);
    send_request(ACT_READ, 5'(CAPACITY - 1), '0);
    send_request(ACT_WRITE, '0, '1);
    send_request(ACT_REMOVE, 5'(CAPACITY - 1), '0);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_INSERT, 5'd5, 32'h0000_ffff);
    send_request(ACT_READ, '1, '0);
    send_request(ACT_SPARE_A, '1, '1);
    send_request(ACT_SPARE_B, '0, '0);
    wait_drained();

    // random requests under each handshake mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[2'(ph)];
      stall_pct     = stall_mix[2'(ph)];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result hold-off while requests keep coming
        if (i == PHASE_ITEMS / 2 && (ph == 0 || ph == 3)) begin
          send_idle_pct = 0;
          hold_request  = 1'b1;
          for (int j = 0; j < BURST_ITEMS; j++) send_random_request();
          send_idle_pct = idle_mix[2'(ph)];
        end
        send_random_request();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    $display("indexed_array_list_tb: %0d requests sent, %0d results checked", sent_count,
             checked);
    $display("indexed_array_list_tb: %0d out-of-range and %0d full outcomes, four stall mixes",
             range_hits, full_hits);
    if (err_count == 0) begin
      $display("indexed_array_list_tb: done, clean");
    end else begin
      $display("indexed_array_list_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ial_pkg.sv
rtl/core/ial_cell.sv
rtl/core/ial_ctrl.sv
rtl/core/indexed_array_list.sv
dv/ial_checker.sv
dv/indexed_array_list_tb.sv
